// ----- rtl/bwns_pkg.sv -----
`timescale 1ns / 1ps

package bwns_pkg;

  // Table geometry
  localparam int MAX_NODES    = 16384;
  localparam int BUCKET_NODES = 1024;
  localparam int NUM_BUCKETS  = (MAX_NODES + BUCKET_NODES - 1) / BUCKET_NODES;

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int NODE_W = $clog2(MAX_NODES + 1);
  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int OFF_W  = $clog2(BUCKET_NODES);

  // Field widths
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 16;
  localparam int SUM_W  = 32;
  localparam int BASE_W = 8;
  localparam int AMT_W  = 8;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(4);
  localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD_NODE   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_AMOUNT = 2'd1;
  localparam logic [OP_W-1:0] OP_SELECT     = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE       = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] node_index;
    logic [AMT_W-1:0] amount;
    logic [SUM_W-1:0] target;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_node;
    logic [ST_W-1:0]  status;
    logic [SUM_W-1:0] total_weight;
  } out_word_t;

  // Request to the shared add/compare unit: a + b + mul_n * base, compared to target
  typedef struct packed {
    logic [SUM_W-1:0]  a;
    logic [SUM_W-1:0]  b;
    logic [NODE_W-1:0] mul_n;
    logic [BASE_W-1:0] base;
    logic [SUM_W-1:0]  target;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             gt;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_BKT_LOAD,
    S_BKT_TEST,
    S_NODE_RD,
    S_NODE_ACC,
    S_AMT_WR,
    S_AMT_SUM,
    S_RESP
  } state_t;

endpackage

// ----- rtl/bwns_ram.sv -----
`timescale 1ns / 1ps

module bwns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry; read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/bwns_alu.sv -----
`timescale 1ns / 1ps

module bwns_alu
  import bwns_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [NODE_W+BASE_W-1:0] prod;

  // Scale the node count by the base weight, add both operands, test against target
  always_comb begin
    prod    = NODE_W'(req.mul_n) * (NODE_W+BASE_W)'(req.base);
    rsp.sum = req.a + req.b + SUM_W'(prod);
    rsp.gt  = rsp.sum > req.target;
  end

endmodule

// ----- rtl/bucketed_weighted_node_sampler.sv -----
`timescale 1ns / 1ps

// Channel   Ports                     Handshake
// --------  ------------------------  ----------------------------------------
// item      start, busy, item         word taken at an edge with start & !busy
// result    done, result              one word per item, valid while done high
// config    cfg_we, cfg_data          base weight written at an edge with cfg_we
//
// One shared add/scale/compare unit does every weight sum and compare under a small sequencer.
// Add node passes decode and response; add amount adds a count and bucket-sum write
// step and a total step; select loads and tests each examined bucket, then reads and
// accumulates each examined node through the registered read of the count RAM, with
// one more read step if the node scan runs past the last node.
// Reset (rst, synchronous) empties the table and sets base weight to 4.
// The receiver cannot stall; busy stays high until the result word is out.
module bucketed_weighted_node_sampler
  import bwns_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_word_t          item,
  output logic              done,
  output out_word_t         result,
  input  logic              cfg_we,
  input  logic [BASE_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [BASE_W-1:0] base_weight;
  logic [NODE_W-1:0] node_total, node_total_next;
  logic [SUM_W-1:0]  weight_sum, weight_sum_next;
  logic [SUM_W-1:0]  bucket_sums [NUM_BUCKETS];
  logic              bkt_we;
  logic [BKT_W-1:0]  bsel;
  logic [SUM_W-1:0]  bsum;

  // Latched input word
  logic [OP_W-1:0]  op_reg;
  logic [IDX_W-1:0] idx_reg;
  logic [AMT_W-1:0] amt_reg;
  logic [SUM_W-1:0] target_reg;

  // Scan registers
  logic [SUM_W-1:0]  acc, acc_next;
  logic [SUM_W-1:0]  bw, bw_next;
  logic [BKT_W-1:0]  bkt, bkt_next;
  logic [NODE_W-1:0] ptr, ptr_next;
  logic [AMT_W-1:0]  add_reg, add_next;
  logic [IDX_W-1:0]  res_node, res_node_next;
  logic [ST_W-1:0]   res_status, res_status_next;

  // Count RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [CNT_W-1:0] ram_wdata;
  logic [CNT_W-1:0] ram_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [NODE_W-1:0] first;
  logic [NODE_W-1:0] present;
  logic [CNT_W-1:0]  room;
  logic [AMT_W-1:0]  addv;
  logic [BKT_W-1:0]  idx_bkt;

  bwns_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_NODES)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bwns_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign busy = (state != S_IDLE);

  // Pick the one bucket sum in use this cycle
  assign idx_bkt = BKT_W'(idx_reg >> OFF_W);
  assign bsel    = (state == S_AMT_WR) ? idx_bkt : bkt;
  assign bsum    = bucket_sums[bsel];

  // Count of present nodes in the scanned bucket
  always_comb begin
    first   = NODE_W'(bkt) << OFF_W;
    present = '0;
    if (node_total > first) begin
      present = node_total - first;
      if (present > NODE_W'(BUCKET_NODES)) begin
        present = NODE_W'(BUCKET_NODES);
      end
    end
  end

  // Saturate the added amount against the stored count
  always_comb begin
    room = COUNT_MAX - ram_rdata;
    addv = (CNT_W'(amt_reg) > room) ? room[AMT_W-1:0] : amt_reg;
  end

  // Sequence the operation and steer the shared unit
  always_comb begin
    state_next      = state;
    node_total_next = node_total;
    weight_sum_next = weight_sum;
    acc_next        = acc;
    bw_next         = bw;
    bkt_next        = bkt;
    ptr_next        = ptr;
    add_next        = add_reg;
    res_node_next   = res_node;
    res_status_next = res_status;
    bkt_we          = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = idx_reg;
    ram_wdata       = '0;
    alu_req.a       = '0;
    alu_req.b       = '0;
    alu_req.mul_n   = '0;
    alu_req.base    = base_weight;
    alu_req.target  = target_reg;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        res_node_next   = '0;
        res_status_next = ST_OK;
        state_next      = S_RESP;
        case (op_reg)
          OP_ADD_NODE: begin
            if (node_total == NODE_W'(MAX_NODES)) begin
              res_status_next = ST_FULL;
            end else begin
              ram_we          = 1'b1;
              ram_addr        = node_total[IDX_W-1:0];
              node_total_next = node_total + NODE_W'(1);
              res_node_next   = node_total[IDX_W-1:0];
            end
          end
          OP_ADD_AMOUNT: begin
            res_node_next = idx_reg;
            if (NODE_W'(idx_reg) >= node_total) begin
              res_status_next = ST_ABSENT;
            end else begin
              state_next = S_AMT_WR;
            end
          end
          OP_SELECT: begin
            alu_req.a     = weight_sum;
            alu_req.mul_n = node_total;
            if (!alu_rsp.gt) begin
              res_status_next = ST_RANGE;
            end else begin
              acc_next   = '0;
              bkt_next   = '0;
              state_next = S_BKT_LOAD;
            end
          end
          default: begin
          end
        endcase
      end

      S_BKT_LOAD: begin
        alu_req.a     = bsum;
        alu_req.mul_n = present;
        bw_next       = alu_rsp.sum;
        state_next    = S_BKT_TEST;
      end

      S_BKT_TEST: begin
        alu_req.a = acc;
        alu_req.b = bw;
        if (bkt != BKT_W'(NUM_BUCKETS - 1) && !alu_rsp.gt) begin
          acc_next   = alu_rsp.sum;
          bkt_next   = bkt + BKT_W'(1);
          state_next = S_BKT_LOAD;
        end else begin
          ptr_next   = NODE_W'(bkt) << OFF_W;
          state_next = S_NODE_RD;
        end
      end

      S_NODE_RD: begin
        ram_addr = ptr[IDX_W-1:0];
        if (ptr >= node_total) begin
          res_node_next = (node_total == '0) ? '0 : IDX_W'(node_total - NODE_W'(1));
          state_next    = S_RESP;
        end else begin
          state_next = S_NODE_ACC;
        end
      end

      S_NODE_ACC: begin
        alu_req.a     = acc;
        alu_req.b     = SUM_W'(ram_rdata);
        alu_req.mul_n = NODE_W'(1);
        if (alu_rsp.gt) begin
          res_node_next = ptr[IDX_W-1:0];
          state_next    = S_RESP;
        end else begin
          acc_next   = alu_rsp.sum;
          ptr_next   = ptr + NODE_W'(1);
          state_next = S_NODE_RD;
        end
      end

      S_AMT_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata + CNT_W'(addv);
        alu_req.a  = bsum;
        alu_req.b  = SUM_W'(addv);
        bkt_we     = 1'b1;
        add_next   = addv;
        state_next = S_AMT_SUM;
      end

      S_AMT_SUM: begin
        alu_req.a       = weight_sum;
        alu_req.b       = SUM_W'(add_reg);
        weight_sum_next = alu_rsp.sum;
        state_next      = S_RESP;
      end

      S_RESP: begin
        alu_req.a     = weight_sum;
        alu_req.mul_n = node_total;
        state_next    = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      base_weight <= BASE_RESET;
      node_total  <= '0;
      weight_sum  <= '0;
      done        <= 1'b0;
      for (int k = 0; k < NUM_BUCKETS; k++) begin
        bucket_sums[BKT_W'(k)] <= '0;
      end
    end else begin
      state      <= state_next;
      node_total <= node_total_next;
      weight_sum <= weight_sum_next;
      done       <= (state == S_RESP);
      if (cfg_we) begin
        base_weight <= cfg_data;
      end
      if (bkt_we) begin
        bucket_sums[bsel] <= alu_rsp.sum;
      end
    end
  end

  // Latch the input word and advance the scan registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_reg     <= item.operation;
      idx_reg    <= item.node_index;
      amt_reg    <= item.amount;
      target_reg <= item.target;
    end
    acc        <= acc_next;
    bw         <= bw_next;
    bkt        <= bkt_next;
    ptr        <= ptr_next;
    add_reg    <= add_next;
    res_node   <= res_node_next;
    res_status <= res_status_next;
    if (state == S_RESP) begin
      result.chosen_node  <= res_node;
      result.status       <= res_status;
      result.total_weight <= alu_rsp.sum;
    end
  end

endmodule
